FILE: rtl/fsc_pkg.sv
// shared types and codes for the frustum sphere cull unit
package fsc_pkg;

	// input word commands
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TEST = 1'b1;

	// sequencer states
	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_RDCOL = 10'b00_0000_0010,
		S_COMP  = 10'b00_0000_0100,
		S_SQ    = 10'b00_0000_1000,
		S_SQEND = 10'b00_0001_0000,
		S_SQRT  = 10'b00_0010_0000,
		S_DIV   = 10'b00_0100_0000,
		S_DIVWR = 10'b00_1000_0000,
		S_TMUL  = 10'b01_0000_0000,
		S_TEND  = 10'b10_0000_0000
	} state_t;

endpackage

FILE: rtl/frustum_sphere_cull_unit.sv
// frustum plane extraction and sphere cull, one shared multiplier under a sequencer
// sphere test: busy after the accepting edge until all six planes are checked, done strobes in the cycle after.
// column loads 0..2 leave the block ready; a load of column 3 then keeps busy high through
// plane extraction, bounded by the bit-serial square root (32 steps) and divider
// (33 + FRAC_BITS steps per component).
// arst_n returns the sequencer to idle and clears all planes to zero; results cannot be stalled.
module frustum_sphere_cull_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cmd,
	input  logic [1:0]         column_index,
	input  logic signed [31:0] m_row0,
	input  logic signed [31:0] m_row1,
	input  logic signed [31:0] m_row2,
	input  logic signed [31:0] m_row3,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic [30:0]        sphere_radius,
	output logic               done,
	output logic               inside_res
);
	import fsc_pkg::*;

	localparam int DW = 33 + FRAC_BITS;
	localparam int CW = $clog2(DW);

	state_t state_q;
	logic [2:0] p_q;
	logic [1:0] k_q;
	logic [CW-1:0] cnt_q;
	logic accept;

	logic [127:0] mat_mem [4];
	logic [127:0] mat_rd_q;
	logic [32:0] mag_q [4];
	logic neg_q [4];
	logic signed [31:0] plane_q [24];
	logic signed [31:0] px_q, py_q, pz_q;
	logic [30:0] rad_in_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p, prod_q, acc_q, acc_sum, wr_term;
	logic signed [32:0] wr_sum;
	logic prod_v_q, prod_first_q;

	logic [63:0] rad_q;
	logic [34:0] srem_q, srem_sh, strial;
	logic [31:0] root_q, root_n, len_q;
	logic sqrt_ge;
	logic [DW-1:0] num_q;
	logic [32:0] drem_q, drem_sh;
	logic div_ge;

	logic [31:0] row_sel;
	logic signed [32:0] ca, cb, cval;
	logic [32:0] cmag;
	logic big;
	logic [1:0] mag_idx;
	logic [32:0] mag_sel;
	logic [31:0] sat_val;
	logic inside_q, res_q, done_q;

	assign accept = start && !busy;
	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign inside_res = res_q;

	// matrix column memory
	always_ff @(posedge clk) begin
		if (accept && cmd == CMD_LOAD) begin
			mat_mem[column_index] <= {m_row3, m_row2, m_row1, m_row0};
		end
		mat_rd_q <= mat_mem[k_q];
	end

	// raw plane component from column k
	always_comb begin
		case (p_q[2:1])
			2'd0: row_sel = mat_rd_q[31:0];
			2'd1: row_sel = mat_rd_q[63:32];
			default: row_sel = mat_rd_q[95:64];
		endcase
		ca = {mat_rd_q[127], mat_rd_q[127:96]};
		cb = {row_sel[31], row_sel};
		cval = p_q[0] ? (ca - cb) : (ca + cb);
		cmag = cval[32] ? 33'(-cval) : 33'(cval);
		big = (mag_q[0][32:31] != 2'b00) || (mag_q[1][32:31] != 2'b00)
			|| (mag_q[2][32:31] != 2'b00);
	end

	// magnitude read port
	assign mag_idx = (state_q == S_DIVWR) ? 2'(k_q + 2'd1) : k_q;
	assign mag_sel = mag_q[mag_idx];

	// shared multiplier operands
	always_comb begin
		if (state_q == S_SQ) begin
			mul_a = signed'(mag_sel);
			mul_b = signed'(mag_sel);
		end else begin
			mul_a = {plane_q[{p_q, k_q}][31], plane_q[{p_q, k_q}]};
			case (k_q)
				2'd0: mul_b = {px_q[31], px_q};
				2'd1: mul_b = {py_q[31], py_q};
				default: mul_b = {pz_q[31], pz_q};
			endcase
		end
		mul_p = mul_a * mul_b;
		wr_sum = {plane_q[{p_q, 2'd3}][31], plane_q[{p_q, 2'd3}]} + signed'({2'b00, rad_in_q});
		wr_term = {{33{wr_sum[32]}}, wr_sum} <<< FRAC_BITS;
		acc_sum = (prod_first_q ? 66'sd0 : acc_q) + prod_q;
	end

	// square root and divide steps
	always_comb begin
		srem_sh = {srem_q[32:0], rad_q[63:62]};
		strial = {1'b0, root_q, 2'b01};
		sqrt_ge = (srem_sh >= strial);
		root_n = {root_q[30:0], sqrt_ge};
		drem_sh = {drem_q[31:0], num_q[DW-1]};
		div_ge = (drem_sh >= {1'b0, len_q});
	end

	// saturate and sign the quotient
	always_comb begin
		if (neg_q[k_q]) begin
			sat_val = (num_q[DW-1:31] != '0) ? 32'h8000_0000 : 32'(-num_q[31:0]);
		end else begin
			sat_val = (num_q[DW-1:31] != '0) ? 32'h7FFF_FFFF : num_q[31:0];
		end
	end

	// product pipeline and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_v_q <= 1'b0;
			prod_first_q <= 1'b0;
		end else begin
			prod_v_q <= (state_q == S_SQ) || (state_q == S_TMUL);
			prod_first_q <= (k_q == 2'd0);
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= (state_q == S_TMUL && k_q == 2'd3) ? wr_term : mul_p;
		if (prod_v_q) begin
			acc_q <= acc_sum;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			p_q <= '0;
			k_q <= '0;
			cnt_q <= '0;
			inside_q <= 1'b1;
			res_q <= 1'b0;
			done_q <= 1'b0;
			for (int i = 0; i < 24; i++) begin
				plane_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					p_q <= '0;
					k_q <= '0;
					inside_q <= 1'b1;
					if (accept) begin
						if (cmd == CMD_TEST) begin
							state_q <= S_TMUL;
						end else if (column_index == 2'd3) begin
							state_q <= S_RDCOL;
						end
					end
				end
				S_RDCOL: state_q <= S_COMP;
				S_COMP: begin
					k_q <= 2'(k_q + 2'd1);
					state_q <= (k_q == 2'd3) ? S_SQ : S_RDCOL;
				end
				S_SQ: begin
					if (k_q == 2'd2) begin
						k_q <= '0;
						state_q <= S_SQEND;
					end else begin
						k_q <= 2'(k_q + 2'd1);
					end
				end
				S_SQEND: begin
					cnt_q <= CW'(31);
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					cnt_q <= CW'(cnt_q - 1'b1);
					if (cnt_q == '0) begin
						if (root_n == '0) begin
							for (int j = 0; j < 4; j++) begin
								plane_q[{p_q, 2'(j)}] <= '0;
							end
							p_q <= 3'(p_q + 3'd1);
							state_q <= (p_q == 3'd5) ? S_IDLE : S_RDCOL;
						end else begin
							cnt_q <= CW'(DW - 1);
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					cnt_q <= CW'(cnt_q - 1'b1);
					if (cnt_q == '0) begin
						state_q <= S_DIVWR;
					end
				end
				S_DIVWR: begin
					plane_q[{p_q, k_q}] <= signed'(sat_val);
					k_q <= 2'(k_q + 2'd1);
					if (k_q == 2'd3) begin
						p_q <= 3'(p_q + 3'd1);
						state_q <= (p_q == 3'd5) ? S_IDLE : S_RDCOL;
					end else begin
						cnt_q <= CW'(DW - 1);
						state_q <= S_DIV;
					end
				end
				S_TMUL: begin
					k_q <= 2'(k_q + 2'd1);
					if (k_q == 2'd3) begin
						state_q <= S_TEND;
					end
				end
				S_TEND: begin
					k_q <= '0;
					if (acc_sum[65]) begin
						inside_q <= 1'b0;
					end
					if (p_q == 3'd5) begin
						res_q <= inside_q && !acc_sum[65];
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						p_q <= 3'(p_q + 3'd1);
						state_q <= S_TMUL;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept && cmd == CMD_TEST) begin
			px_q <= pos_x;
			py_q <= pos_y;
			pz_q <= pos_z;
			rad_in_q <= sphere_radius;
		end
		if (state_q == S_COMP) begin
			neg_q[k_q] <= cval[32];
			if (k_q == 2'd3) begin
				for (int j = 0; j < 3; j++) begin
					mag_q[j] <= big ? (mag_q[j] >> 1) : mag_q[j];
				end
				mag_q[3] <= big ? (cmag >> 1) : cmag;
			end else begin
				mag_q[k_q] <= cmag;
			end
		end
		if (state_q == S_SQEND) begin
			rad_q <= acc_sum[63:0];
			srem_q <= '0;
			root_q <= '0;
		end
		if (state_q == S_SQRT) begin
			rad_q <= {rad_q[61:0], 2'b00};
			srem_q <= sqrt_ge ? (srem_sh - strial) : srem_sh;
			root_q <= root_n;
			if (cnt_q == '0) begin
				len_q <= root_n;
				num_q <= {mag_sel, FRAC_BITS'(0)};
				drem_q <= '0;
			end
		end
		if (state_q == S_DIV) begin
			drem_q <= div_ge ? (drem_sh - {1'b0, len_q}) : drem_sh;
			num_q <= {num_q[DW-2:0], div_ge};
		end
		if (state_q == S_DIVWR && k_q != 2'd3) begin
			num_q <= {mag_sel, FRAC_BITS'(0)};
			drem_q <= '0;
		end
	end

	// checks
	a_done_from_tend: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_TEND))
		else $error("result strobe without final plane check");
	a_test_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_TEST) |=> (state_q == S_TMUL))
		else $error("test word did not start the multiply walk");
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (drem_q < {1'b0, len_q}))
		else $error("divider remainder out of range");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (len_q != '0))
		else $error("divide by zero length");

endmodule
